// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the fan tach RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hw/rtl/fantach_pkg.sv =====
// Types, constants and a helper function for the fan tach / PWM duty block.
package fantach_pkg;

    // arithmetic constants
    localparam logic [15:0] RPM_SCALE = 16'd60000;
    localparam logic [15:0] RPM_MAX   = 16'hFFFF;
    localparam logic [14:0] DUTY_MAX  = 15'd32767;
    localparam logic [7:0]  BYTE_MAX  = 8'd255;

    // item actions
    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_SET  = 1'b1;

    // configuration register indexes
    localparam logic [1:0] REG_PERIOD_TOP = 2'd0;
    localparam logic [1:0] REG_WINDOW_MS  = 2'd1;
    localparam logic [1:0] REG_PPR        = 2'd2;
    localparam logic [1:0] REG_STEP       = 2'd3;

    // configuration reset values
    localparam logic [15:0] RST_PERIOD_TOP = 16'd2879;
    localparam logic [15:0] RST_WINDOW_MS  = 16'd1000;
    localparam logic [7:0]  RST_PPR        = 8'd2;
    localparam logic [7:0]  RST_STEP       = 8'd30;

    typedef struct packed {
        logic [15:0] period_top;
        logic [15:0] window_ms;
        logic [7:0]  ppr;
        logic [7:0]  step;
    } t_cfg;

    // classified item passed from front to back
    typedef struct packed {
        logic        is_set;
        logic        closed;
        logic [31:0] edges;
        logic [31:0] elapsed;
        logic [14:0] duty;
    } t_cmd;

    // exact x / 32767 using 32767 = 2^15 - 1 folding
    function automatic logic [17:0] div32767(input logic [31:0] x);
        logic [16:0] a;
        logic [17:0] s;
        logic [2:0]  c;
        logic [15:0] t;
        logic [17:0] q;
        a = x[31:15];
        s = 18'(a) + 18'(x[14:0]);
        c = s[17:15];
        t = 16'(c) + 16'(s[14:0]);
        q = 18'(a) + 18'(c) + ((t >= 16'(DUTY_MAX)) ? 18'd1 : 18'd0);
        return q;
    endfunction

endpackage

// ===== hw/rtl/fan_tach_rpm_and_pwm_duty.sv =====
// Top level: fan tach rpm meter and PWM duty holder with config registers.
//
//  channel  dir  handshake             beat carries
//  in       in   i_in_valid/o_in_stall action, tach_level, now_ms, duty_request
//  out      out  o_out_valid/i_out_stall rpm, duty, compare, duty/speed bytes, done
//  cfg      in   i_cfg_valid/o_cfg_ready register index, 16-bit data
//
// A set item or a tick that closes no window runs only the speed-byte division in
// the back end; a closing tick runs 16 rpm quotient bits, then 8 speed-byte bits,
// through one shared shift-subtract divider. A zero divisor or a saturated quotient
// skips its divide steps. The front takes one item per cycle into a QUEUE_DEPTH
// queue and stalls only when it is full. Output stall holds the result register
// and the back end waits in its output state. Reset is synchronous, active low.
module fan_tach_rpm_and_pwm_duty #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_action,
    input  logic        i_tach_level,
    input  logic [31:0] i_now_ms,
    input  logic [15:0] i_duty_request,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_rpm_value,
    output logic [14:0] o_duty_now,
    output logic [16:0] o_compare_value,
    output logic [7:0]  o_duty_byte,
    output logic [7:0]  o_speed_byte,
    output logic        o_window_done,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import fantach_pkg::*;

    t_cfg r_cfg;
    t_cmd push_cmd;
    t_cmd head_cmd;
    logic push;
    logic pop;
    logic full;
    logic empty;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.period_top <= RST_PERIOD_TOP;
            r_cfg.window_ms  <= RST_WINDOW_MS;
            r_cfg.ppr        <= RST_PPR;
            r_cfg.step       <= RST_STEP;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_PERIOD_TOP: r_cfg.period_top <= i_cfg_data;
                REG_WINDOW_MS:  r_cfg.window_ms  <= i_cfg_data;
                REG_PPR:        r_cfg.ppr        <= i_cfg_data[7:0];
                REG_STEP:       r_cfg.step       <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    fantach_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_tach_level   (i_tach_level),
        .i_now_ms       (i_now_ms),
        .i_duty_request (i_duty_request),
        .i_window_ms    (r_cfg.window_ms),
        .i_full         (full),
        .o_push         (push),
        .o_cmd          (push_cmd)
    );

    fantach_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_full  (full),
        .o_empty (empty)
    );

    fantach_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_empty         (empty),
        .i_cmd           (head_cmd),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_rpm_value     (o_rpm_value),
        .o_duty_now      (o_duty_now),
        .o_compare_value (o_compare_value),
        .o_duty_byte     (o_duty_byte),
        .o_speed_byte    (o_speed_byte),
        .o_window_done   (o_window_done)
    );

endmodule

// ===== hw/rtl/fantach_front.sv =====
// Front end: accepts items, tracks tach edges and windows, emits commands.
module fantach_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_action,
    input  logic                 i_tach_level,
    input  logic [31:0]          i_now_ms,
    input  logic [15:0]          i_duty_request,
    input  logic [15:0]          i_window_ms,
    input  logic                 i_full,
    output logic                 o_push,
    output fantach_pkg::t_cmd    o_cmd
);
    import fantach_pkg::*;

    logic        r_last_level, n_last_level;
    logic        r_level_seen, n_level_seen;
    logic [31:0] r_edge_count, n_edge_count;
    logic [31:0] r_window_start, n_window_start;

    logic        accept;
    logic        falling;
    logic [31:0] elapsed;
    logic [31:0] edges_inc;
    logic        closed;

    assign o_in_stall = i_full;
    assign accept     = i_in_valid & ~i_full;
    assign o_push     = accept;

    // edge detect and window test
    always_comb begin
        falling   = r_level_seen & r_last_level & ~i_tach_level;
        edges_inc = r_edge_count + 32'(falling);
        elapsed   = i_now_ms - r_window_start;
        closed    = elapsed >= 32'(i_window_ms);

        o_cmd.is_set  = (i_action == ACT_SET);
        o_cmd.closed  = (i_action == ACT_TICK) & closed;
        o_cmd.edges   = edges_inc;
        o_cmd.elapsed = elapsed;
        o_cmd.duty    = i_duty_request[15] ? DUTY_MAX : i_duty_request[14:0];
    end

    // tach state update on a tick beat
    always_comb begin
        n_last_level   = r_last_level;
        n_level_seen   = r_level_seen;
        n_edge_count   = r_edge_count;
        n_window_start = r_window_start;
        if (accept && i_action == ACT_TICK) begin
            n_level_seen = 1'b1;
            n_last_level = i_tach_level;
            if (closed) begin
                n_edge_count   = '0;
                n_window_start = i_now_ms;
            end else begin
                n_edge_count = edges_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_level   <= 1'b1;
            r_level_seen   <= 1'b0;
            r_edge_count   <= '0;
            r_window_start <= '0;
        end else begin
            r_last_level   <= n_last_level;
            r_level_seen   <= n_level_seen;
            r_edge_count   <= n_edge_count;
            r_window_start <= n_window_start;
        end
    end

endmodule

// ===== hw/rtl/fantach_fifo.sv =====
// Short command queue between front and back.
`include "assert_macros.svh"
module fantach_fifo #(
    parameter int DEPTH = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  fantach_pkg::t_cmd    i_cmd,
    input  logic                 i_pop,
    output fantach_pkg::t_cmd    o_cmd,
    output logic                 o_full,
    output logic                 o_empty
);
    import fantach_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd            r_slot [DEPTH];
    logic [PW-1:0]   r_wr, n_wr;
    logic [PW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_count, n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_slot[r_rd];

    // pointer and fill count
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_cmd;
        end
    end

    `ASSERT_CLK(a_no_overflow, r_count == CW'(DEPTH) |-> !i_push, "push into full queue")
    `ASSERT_CLK(a_no_underflow, r_count == '0 |-> !i_pop, "pop from empty queue")

endmodule

// ===== hw/rtl/fantach_back.sv =====
// Back end: rpm and speed-byte division, duty scaling, output register.
`include "assert_macros.svh"
module fantach_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fantach_pkg::t_cfg    i_cfg,
    input  logic                 i_empty,
    input  fantach_pkg::t_cmd    i_cmd,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [15:0]          o_rpm_value,
    output logic [14:0]          o_duty_now,
    output logic [16:0]          o_compare_value,
    output logic [7:0]           o_duty_byte,
    output logic [7:0]           o_speed_byte,
    output logic                 o_window_done
);
    import fantach_pkg::*;

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_SAT  = 2'd1;
    localparam logic [1:0] B_DIV  = 2'd2;
    localparam logic [1:0] B_OUT  = 2'd3;

    // control state
    logic [1:0]  r_state, n_state;
    logic        r_out_valid, n_out_valid;
    logic [15:0] r_speed, n_speed;
    logic [14:0] r_duty, n_duty;

    // divider datapath and result payload
    logic        r_closed, n_closed;
    logic        r_byte, n_byte;
    logic [47:0] r_rem, n_rem;
    logic [39:0] r_div, n_div;
    logic [54:0] r_dsh, n_dsh;
    logic [15:0] r_quo, n_quo;
    logic [3:0]  r_cnt, n_cnt;
    logic [7:0]  r_sbyte, n_sbyte;
    logic [15:0] r_o_rpm, n_o_rpm;
    logic [14:0] r_o_duty, n_o_duty;
    logic [16:0] r_o_cmp, n_o_cmp;
    logic [7:0]  r_o_dbyte, n_o_dbyte;
    logic [7:0]  r_o_sbyte, n_o_sbyte;
    logic        r_o_done, n_o_done;

    logic        fin;
    logic [15:0] fin_val;
    logic [55:0] lim;
    logic        ge;
    logic [15:0] q_next;
    logic [16:0] top1;
    logic [31:0] cmp_prod;
    logic [31:0] dby_prod;
    logic [17:0] cmp_q;
    logic [17:0] dby_q;
    logic        load;

    assign o_pop = (r_state == B_IDLE) & ~i_empty;
    assign load  = ~r_out_valid | ~i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid & i_out_stall;
        n_speed     = r_speed;
        n_duty      = r_duty;
        n_closed    = r_closed;
        n_byte      = r_byte;
        n_rem       = r_rem;
        n_div       = r_div;
        n_dsh       = r_dsh;
        n_quo       = r_quo;
        n_cnt       = r_cnt;
        n_sbyte     = r_sbyte;
        n_o_rpm     = r_o_rpm;
        n_o_duty    = r_o_duty;
        n_o_cmp     = r_o_cmp;
        n_o_dbyte   = r_o_dbyte;
        n_o_sbyte   = r_o_sbyte;
        n_o_done    = r_o_done;

        fin      = 1'b0;
        fin_val  = '0;
        lim      = r_byte ? {8'b0, r_div, 8'b0} : {r_div, 16'b0};
        ge       = {7'b0, r_rem} >= r_dsh;
        q_next   = {r_quo[14:0], ge};
        top1     = 17'(i_cfg.period_top) + 17'd1;
        cmp_prod = 32'(top1) * 32'(r_duty);
        dby_prod = 32'(r_duty) * 32'(BYTE_MAX);
        cmp_q    = div32767(cmp_prod);
        dby_q    = div32767(dby_prod);

        case (r_state)
            // take a command: set duty on a set item, and start the rpm or byte division
            B_IDLE: begin
                if (!i_empty) begin
                    n_closed = i_cmd.closed;
                    if (i_cmd.is_set) begin
                        n_duty = i_cmd.duty;
                    end
                    if (i_cmd.closed) begin
                        n_rem  = 48'(i_cmd.edges) * 48'(RPM_SCALE);
                        n_div  = 40'(i_cmd.elapsed) * 40'(i_cfg.ppr);
                        n_byte = 1'b0;
                    end else begin
                        n_rem  = 48'(r_speed);
                        n_div  = 40'(i_cfg.step);
                        n_byte = 1'b1;
                    end
                    n_state = B_SAT;
                end
            end
            // zero divisor and quotient overflow checks
            B_SAT: begin
                if (r_div == '0) begin
                    fin     = 1'b1;
                    fin_val = r_byte ? 16'(BYTE_MAX) : 16'd0;
                end else if ({8'b0, r_rem} >= lim) begin
                    fin     = 1'b1;
                    fin_val = r_byte ? 16'(BYTE_MAX) : RPM_MAX;
                end else begin
                    n_dsh   = r_byte ? (55'(r_div) << 7) : (55'(r_div) << 15);
                    n_cnt   = r_byte ? 4'd7 : 4'd15;
                    n_quo   = '0;
                    n_state = B_DIV;
                end
            end
            // restoring division, one quotient bit a cycle
            B_DIV: begin
                if (ge) begin
                    n_rem = r_rem - r_dsh[47:0];
                end
                n_dsh = r_dsh >> 1;
                n_cnt = r_cnt - 4'd1;
                n_quo = q_next;
                if (r_cnt == '0) begin
                    fin     = 1'b1;
                    fin_val = q_next;
                end
            end
            // load the output register once it is free
            B_OUT: begin
                if (load) begin
                    n_out_valid = 1'b1;
                    n_o_rpm     = r_speed;
                    n_o_duty    = r_duty;
                    n_o_cmp     = cmp_q[16:0];
                    n_o_dbyte   = dby_q[7:0];
                    n_o_sbyte   = r_sbyte;
                    n_o_done    = r_closed;
                    n_state     = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase

        // division finished: rpm goes on to the speed byte, the speed byte to the output state
        if (fin) begin
            if (!r_byte) begin
                n_speed = fin_val;
                n_rem   = 48'(fin_val);
                n_div   = 40'(i_cfg.step);
                n_byte  = 1'b1;
                n_state = B_SAT;
            end else begin
                n_sbyte = fin_val[7:0];
                n_state = B_OUT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
            r_speed     <= '0;
            r_duty      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_speed     <= n_speed;
            r_duty      <= n_duty;
        end
    end

    always_ff @(posedge i_clk) begin
        r_closed  <= n_closed;
        r_byte    <= n_byte;
        r_rem     <= n_rem;
        r_div     <= n_div;
        r_dsh     <= n_dsh;
        r_quo     <= n_quo;
        r_cnt     <= n_cnt;
        r_sbyte   <= n_sbyte;
        r_o_rpm   <= n_o_rpm;
        r_o_duty  <= n_o_duty;
        r_o_cmp   <= n_o_cmp;
        r_o_dbyte <= n_o_dbyte;
        r_o_sbyte <= n_o_sbyte;
        r_o_done  <= n_o_done;
    end

    assign o_out_valid     = r_out_valid;
    assign o_rpm_value     = r_o_rpm;
    assign o_duty_now      = r_o_duty;
    assign o_compare_value = r_o_cmp;
    assign o_duty_byte     = r_o_dbyte;
    assign o_speed_byte    = r_o_sbyte;
    assign o_window_done   = r_o_done;

    `ASSERT_CLK(a_div_nonzero, r_state == B_DIV |-> r_div != '0, "divide step with zero divisor")
    `ASSERT_CLK(a_out_from_out, $rose(r_out_valid) |-> $past(r_state) == B_OUT, "result beat not from output state")

endmodule

// ===== tb/tb_fan_tach_rpm_and_pwm_duty.sv =====
// Self-checking testbench for the fan tach rpm meter and PWM duty holder.
module tb_fan_tach_rpm_and_pwm_duty;
    timeunit 1ns;
    timeprecision 1ps;

    import fantach_pkg::*;

    localparam int RESET_CYCLES = 8;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 146;

    // one result beat as seen on the output port
    typedef struct packed {
        logic [15:0] rpm;
        logic [14:0] duty;
        logic [16:0] cmp;
        logic [7:0]  dbyte;
        logic [7:0]  sbyte;
        logic        done;
    } t_reply;

    // Tracks tach/duty state and the register file, queues expected replies
    class rpm_duty_tracker;
        logic [15:0] period_top;
        logic [15:0] window_ms;
        logic [7:0]  ppr;
        logic [7:0]  step;
        logic        last_level;
        logic        level_seen;
        logic [31:0] edge_count;
        logic [31:0] window_start;
        logic [15:0] speed_held;
        logic [14:0] duty_held;
        t_reply      pending[$];
        int          errors;

        function new();
            period_top   = RST_PERIOD_TOP;
            window_ms    = RST_WINDOW_MS;
            ppr          = RST_PPR;
            step         = RST_STEP;
            last_level   = 1'b1;
            level_seen   = 1'b0;
            edge_count   = '0;
            window_start = '0;
            speed_held   = '0;
            duty_held    = '0;
            errors       = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] data);
            case (idx)
                REG_PERIOD_TOP: period_top = data;
                REG_WINDOW_MS:  window_ms  = data;
                REG_PPR:        ppr        = data[7:0];
                REG_STEP:       step       = data[7:0];
                default: ;
            endcase
        endfunction

        // accepted input beat: advance state, queue the reply it causes
        function void note_item(logic act, logic lvl, logic [31:0] now, logic [15:0] req);
            logic [31:0] elapsed;
            logic [63:0] rpm;
            logic [63:0] cmp;
            logic [31:0] dbyte;
            logic [15:0] quot;
            t_reply      r;
            r.done = 1'b0;
            if (act == ACT_TICK) begin
                // first tick only seeds the previous level
                if (!level_seen) begin
                    level_seen = 1'b1;
                end else if (last_level && !lvl) begin
                    edge_count = edge_count + 32'd1;
                end
                last_level = lvl;
                elapsed = now - window_start;
                if (elapsed >= 32'(window_ms)) begin
                    rpm = '0;
                    if (ppr != 8'd0 && elapsed != 32'd0) begin
                        rpm = (64'(edge_count) * 64'(RPM_SCALE)) / (64'(ppr) * 64'(elapsed));
                    end
                    if (rpm > 64'(RPM_MAX)) rpm = 64'(RPM_MAX);
                    speed_held   = rpm[15:0];
                    edge_count   = '0;
                    window_start = now;
                    r.done       = 1'b1;
                end
            end else begin
                duty_held = (req > 16'(DUTY_MAX)) ? DUTY_MAX : req[14:0];
            end
            cmp   = (64'(period_top) + 64'd1) * 64'(duty_held) / 64'(DUTY_MAX);
            dbyte = (32'(duty_held) * 32'(BYTE_MAX)) / 32'(DUTY_MAX);
            if (step == 8'd0) begin
                r.sbyte = BYTE_MAX;
            end else begin
                quot    = speed_held / 16'(step);
                r.sbyte = (quot > 16'(BYTE_MAX)) ? BYTE_MAX : quot[7:0];
            end
            r.rpm   = speed_held;
            r.duty  = duty_held;
            r.cmp   = cmp[16:0];
            r.dbyte = dbyte[7:0];
            pending.push_back(r);
        endfunction

        // accepted output beat: compare with the oldest expected reply
        function void check_reply(t_reply got);
            t_reply want;
            if (pending.size() == 0) begin
                $error("result beat with nothing expected: rpm %0d duty %0d", got.rpm, got.duty);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.rpm !== want.rpm) begin
                $error("rpm_value: expected %0d, actual %0d", want.rpm, got.rpm);
                errors++;
            end
            if (got.duty !== want.duty) begin
                $error("duty_now: expected %0d, actual %0d", want.duty, got.duty);
                errors++;
            end
            if (got.cmp !== want.cmp) begin
                $error("compare_value: expected %0d, actual %0d", want.cmp, got.cmp);
                errors++;
            end
            if (got.dbyte !== want.dbyte) begin
                $error("duty_byte: expected %0d, actual %0d", want.dbyte, got.dbyte);
                errors++;
            end
            if (got.sbyte !== want.sbyte) begin
                $error("speed_byte: expected %0d, actual %0d", want.sbyte, got.sbyte);
                errors++;
            end
            if (got.done !== want.done) begin
                $error("window_done: expected %0d, actual %0d", want.done, got.done);
                errors++;
            end
        endfunction

        function int outstanding();
            return pending.size();
        endfunction
    endclass

    logic        i_clk        = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_action    = ACT_TICK;
    logic        in_level     = 1'b0;
    logic [31:0] in_now       = '0;
    logic [15:0] in_req       = '0;
    logic        out_stall    = 1'b0;
    logic        cfg_valid    = 1'b0;
    logic [1:0]  cfg_index    = REG_PERIOD_TOP;
    logic [15:0] cfg_data     = '0;

    logic        o_in_stall;
    logic        o_out_valid;
    logic [15:0] o_rpm_value;
    logic [14:0] o_duty_now;
    logic [16:0] o_compare_value;
    logic [7:0]  o_duty_byte;
    logic [7:0]  o_speed_byte;
    logic        o_window_done;
    logic        o_cfg_ready;

    bit          idle_on  = 1'b1;
    bit          hold_req = 1'b0;
    logic [31:0] cur_ms   = '0;

    rpm_duty_tracker tracker = new();

    fan_tach_rpm_and_pwm_duty dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (in_action),
        .i_tach_level    (in_level),
        .i_now_ms        (in_now),
        .i_duty_request  (in_req),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (out_stall),
        .o_rpm_value     (o_rpm_value),
        .o_duty_now      (o_duty_now),
        .o_compare_value (o_compare_value),
        .o_duty_byte     (o_duty_byte),
        .o_speed_byte    (o_speed_byte),
        .o_window_done   (o_window_done),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Offer one input beat, with an optional idle burst first
    task automatic send_item(input logic act, input logic lvl, input logic [31:0] now,
                             input logic [15:0] req);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid  <= 1'b1;
        in_action <= act;
        in_level  <= lvl;
        in_now    <= now;
        in_req    <= req;
        do @(posedge i_clk); while (o_in_stall);
        tracker.note_item(act, lvl, now, req);
    endtask

    // Mostly ticks on a forward-running clock, sometimes a time jump or a duty change
    task automatic send_random_item(input logic [15:0] win);
        logic [15:0] req;
        if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 5))
                0:       req = 16'd0;
                1:       req = 16'(DUTY_MAX);
                2:       req = 16'(DUTY_MAX) + 16'd1;
                3:       req = 16'hFFFF;
                default: req = 16'($urandom_range(0, 65535));
            endcase
            send_item(ACT_SET, 1'($urandom_range(0, 1)), $urandom, req);
        end else begin
            if ($urandom_range(0, 39) == 0) begin
                cur_ms = $urandom;
            end else begin
                cur_ms = cur_ms + $urandom_range(0, int'(win) / 16 + 3);
            end
            send_item(ACT_TICK, 1'($urandom_range(0, 1)), cur_ms, 16'($urandom));
        end
    endtask

    // Stop offering and wait out every reply plus the back-end latency
    task automatic drain();
        in_valid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One register beat; valid stays high for a following write
    task automatic write_register(input logic [1:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.write_reg(idx, data);
    endtask

    task automatic write_config(input logic [15:0] top, input logic [15:0] win,
                                input logic [7:0] ppr, input logic [7:0] step);
        write_register(REG_PERIOD_TOP, top);
        write_register(REG_WINDOW_MS, win);
        write_register(REG_PPR, 16'(ppr));
        write_register(REG_STEP, 16'(step));
        cfg_valid <= 1'b0;
    endtask

    // Result sink: check accepted beats, drive stall bursts and the long hold
    initial begin : result_sink
        int     stall_left;
        t_reply got;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (rst_n && o_out_valid && !out_stall) begin
                got = '{rpm: o_rpm_value, duty: o_duty_now, cmp: o_compare_value,
                        dbyte: o_duty_byte, sbyte: o_speed_byte, done: o_window_done};
                tracker.check_reply(got);
            end
            if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 7);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Run limit
    initial begin : watchdog
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        logic [15:0] win;
        repeat (RESET_CYCLES) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // edge counting on reset settings; first tick only seeds the level
        send_item(ACT_TICK, 1'b0, 32'd0, 16'd0);
        send_item(ACT_TICK, 1'b1, 32'd10, 16'd0);
        send_item(ACT_TICK, 1'b0, 32'd20, 16'd0);
        send_item(ACT_TICK, 1'b1, 32'd30, 16'd0);
        send_item(ACT_TICK, 1'b0, 32'd40, 16'd0);
        send_item(ACT_TICK, 1'b1, 32'd1000, 16'hFFFF);
        // duty extremes and clamping
        send_item(ACT_SET, 1'b0, 32'hFFFF_FFFF, 16'd0);
        send_item(ACT_SET, 1'b1, 32'd0, 16'(DUTY_MAX));
        send_item(ACT_SET, 1'b0, 32'd5, 16'(DUTY_MAX) + 16'd1);
        send_item(ACT_SET, 1'b1, 32'd7, 16'hFFFF);
        send_item(ACT_SET, 1'b0, 32'd9, 16'd16384);

        // short window, one pulse per rev: rpm saturates
        drain();
        write_config(16'hFFFF, 16'd2, 8'd1, 8'd1);
        for (int k = 0; k < 6; k++) begin
            send_item(ACT_TICK, 1'(k), 32'd1001, 16'hFFFF);
        end
        send_item(ACT_TICK, 1'b0, 32'd1002, 16'd0);

        // zero window, zero reply step, time wrap
        drain();
        write_config(16'd0, 16'd0, 8'hFF, 8'd0);
        send_item(ACT_TICK, 1'b1, 32'd1002, 16'd0);
        send_item(ACT_TICK, 1'b0, 32'd1003, 16'd0);
        send_item(ACT_TICK, 1'b1, 32'hFFFF_FFFF, 16'd0);
        send_item(ACT_TICK, 1'b0, 32'd3, 16'd0);
        send_item(ACT_SET, 1'b0, 32'd0, 16'(DUTY_MAX));

        // random phases over several register settings
        cur_ms = $urandom;
        for (int p = 0; p < 6; p++) begin
            drain();
            case (p)
                0: write_config(RST_PERIOD_TOP, RST_WINDOW_MS, RST_PPR, RST_STEP);
                1: write_config(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
                2: write_config(16'd0, 16'd0, 8'd0, 8'd0);
                3: write_config(16'd1, 16'd5, 8'd1, 8'd1);
                default: write_config(16'($urandom), 16'($urandom_range(0, 4000)),
                                      8'($urandom), 8'($urandom));
            endcase
            win = tracker.window_ms;
            // long output hold so the input side backs up
            if (p == 3) hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 40 == 0) idle_on = (p != 5) && ($urandom_range(0, 3) != 0);
                send_random_item(win);
            end
        end
        drain();

        if (tracker.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
